// ===== design/tcad_pkg.sv =====
`default_nettype none
package tcad_pkg;

	localparam int SENSORS = 16;
	localparam int CH_W = 4;
	localparam logic [7:0] DEADBAND_RESET = 8'd8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// error timer: seconds = elapsed_ms / 1000, saturating
	localparam int MS_PER_S = 1000;
	localparam int SECS_MAX = 255;
	localparam int SAT_MS = (SECS_MAX + 1) * MS_PER_S;
	localparam int ELAPSED_W = $clog2(SAT_MS);
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP = ((1 << RECIP_SHIFT) + MS_PER_S - 1) / MS_PER_S;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = ELAPSED_W + RECIP_W;

	typedef struct packed {
		logic [CH_W-1:0]    sensor_index;
		logic signed [15:0] reading_centi;
		logic               disconnected;
		logic signed [15:0] offset_centi;
		logic               publish_pass;
		logic               end_of_pass;
		logic [31:0]        now_ms;
	} in_word_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic signed [15:0] average_centi;
		logic signed [15:0] published_centi;
		logic               published_changed;
		logic [7:0]         error_seconds;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic               in_range;
		logic               disconnected;
		logic signed [15:0] value;
		logic               publish;
		logic               eop;
		logic [31:0]        now_ms;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/temp_channel_average_deadband.sv =====
// An accepted word passes the front register, the queue, the table update stage
// and the divide stage, then shows on the result ports.
// One word per cycle while results are popped; the table updates on dequeue.
// Reset (arst_n low, asynchronous): queues empty, averages and published values 0,
// first pass set, error timer idle, deadband 8.
`default_nettype none
module temp_channel_average_deadband (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tcad_pkg::in_word_t  item,
	output logic                     full,
	output logic                     empty,
	input  wire logic                pop,
	output tcad_pkg::out_word_t      result,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_data
);

	logic [7:0]                deadband_q;
	logic                      fr_valid;
	tcad_pkg::cmd_t            fr_cmd;
	logic                      q_full;
	logic                      q_empty;
	logic                      q_rd;
	tcad_pkg::cmd_t            q_data;
	logic [tcad_pkg::QPTR_W:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= tcad_pkg::DEADBAND_RESET;
		end else if (cfg_we) begin
			deadband_q <= cfg_data;
		end
	end

	tcad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.q_full    (q_full),
		.cmd_valid (fr_valid),
		.cmd       (fr_cmd)
	);

	tcad_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fr_valid),
		.wdata  (fr_cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_data),
		.empty  (q_empty),
		.count  (q_count)
	);

	tcad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.deadband (deadband_q),
		.q_empty  (q_empty),
		.cmd      (q_data),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> fr_valid)
		else $error("accepted word not held by front stage");

	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !q_full |=> q_count != '0)
		else $error("queue lost a written word");

	a_changed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.published_changed |->
			result.published_centi == result.average_centi)
		else $error("published value differs from average after update");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !(fr_valid && q_rd && q_empty))
		else $error("queue full and empty at once");

endmodule
`default_nettype wire

// ===== design/tcad_front.sv =====
`default_nettype none
module tcad_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tcad_pkg::in_word_t item,
	output logic                    full,
	input  wire logic               q_full,
	output logic                    cmd_valid,
	output tcad_pkg::cmd_t          cmd
);

	logic               v_s1;
	tcad_pkg::in_word_t item_s1;
	logic               accept;
	logic signed [16:0] sum_w;
	logic signed [15:0] sat_w;

	assign full      = v_s1 && q_full;
	assign accept    = push && !full;
	assign cmd_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// reading + offset, clamped to 16 bits
	assign sum_w = {item_s1.reading_centi[15], item_s1.reading_centi}
		+ {item_s1.offset_centi[15], item_s1.offset_centi};

	always_comb begin
		if (sum_w[16] != sum_w[15]) begin
			sat_w = sum_w[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat_w = sum_w[15:0];
		end
	end

	always_comb begin
		cmd.channel      = item_s1.sensor_index;
		cmd.in_range     = 32'(item_s1.sensor_index) < 32'(tcad_pkg::SENSORS);
		cmd.disconnected = item_s1.disconnected;
		cmd.value        = sat_w;
		cmd.publish      = item_s1.publish_pass;
		cmd.eop          = item_s1.end_of_pass;
		cmd.now_ms       = item_s1.now_ms;
	end

endmodule
`default_nettype wire

// ===== design/tcad_queue.sv =====
`default_nettype none
module tcad_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr,
	input  wire tcad_pkg::cmd_t         wdata,
	output logic                        full,
	input  wire logic                   rd,
	output tcad_pkg::cmd_t              rdata,
	output logic                        empty,
	output logic [tcad_pkg::QPTR_W:0]   count
);

	tcad_pkg::cmd_t                slot_q [tcad_pkg::QUEUE_DEPTH];
	logic [tcad_pkg::QPTR_W-1:0]   wp_q;
	logic [tcad_pkg::QPTR_W-1:0]   rp_q;
	logic [tcad_pkg::QPTR_W:0]     cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full  = cnt_q == (tcad_pkg::QPTR_W+1)'(tcad_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign count = cnt_q;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + tcad_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + tcad_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (tcad_pkg::QPTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (tcad_pkg::QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== design/tcad_back.sv =====
`default_nettype none
module tcad_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      deadband,
	input  wire logic            q_empty,
	input  wire tcad_pkg::cmd_t  cmd,
	output logic                 q_rd,
	output logic                 empty,
	input  wire logic            pop,
	output tcad_pkg::out_word_t  result
);

	logic signed [15:0] avg_q [tcad_pkg::SENSORS];
	logic signed [15:0] pub_q [tcad_pkg::SENSORS];
	logic               first_q;
	logic               err_q;
	logic [31:0]        start_q;

	logic               v1_s1;
	logic               v2_s2;
	logic               ld1;
	logic               ld2;
	logic               take;

	logic signed [15:0] cur_avg;
	logic signed [15:0] cur_pub;
	logic signed [16:0] sum_w;
	logic signed [16:0] rnd_w;
	logic signed [16:0] half_w;
	logic signed [15:0] avg_new;
	logic signed [16:0] diff_w;
	logic signed [16:0] db_w;
	logic signed [16:0] neg_db_w;
	logic               hit;
	logic               live;
	logic               err_now;
	logic [31:0]        start_nx;

	logic [tcad_pkg::CH_W-1:0] ch_s1;
	logic signed [15:0]        avg_s1;
	logic signed [15:0]        pub_s1;
	logic                      chg_s1;
	logic                      timer_s1;
	logic [31:0]               elapsed_s1;

	logic [tcad_pkg::PROD_W-1:0] prod_w;
	logic [7:0]                  secs_w;
	tcad_pkg::out_word_t         res_s2;

	assign ld2   = !v2_s2 || pop;
	assign ld1   = !v1_s1 || ld2;
	assign take  = ld1 && !q_empty;
	assign q_rd  = take;
	assign empty = !v2_s2;
	assign result = res_s2;

	assign cur_avg = avg_q[cmd.channel];
	assign cur_pub = pub_q[cmd.channel];

	// (avg + v) / 2, truncated toward zero
	assign sum_w   = {cur_avg[15], cur_avg} + {cmd.value[15], cmd.value};
	assign rnd_w   = sum_w + 17'(sum_w[16]);
	assign half_w  = rnd_w >>> 1;
	assign avg_new = first_q ? cmd.value : half_w[15:0];

	assign diff_w   = {avg_new[15], avg_new} - {cur_pub[15], cur_pub};
	assign db_w     = {9'd0, deadband};
	assign neg_db_w = -db_w;
	assign hit      = cmd.publish && (diff_w >= db_w || diff_w <= neg_db_w);
	assign live     = cmd.in_range && !cmd.disconnected;

	assign err_now = err_q || (cmd.in_range && cmd.disconnected);

	always_comb begin
		start_nx = start_q;
		if (cmd.eop) begin
			if (!err_now) begin
				start_nx = '0;
			end else if (start_q == '0) begin
				// a start time of zero would read as idle
				start_nx = (cmd.now_ms == '0) ? 32'd1 : cmd.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tcad_pkg::SENSORS; i++) begin
				avg_q[i] <= '0;
				pub_q[i] <= '0;
			end
			first_q <= 1'b1;
			err_q   <= 1'b0;
			start_q <= '0;
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
		end else begin
			if (take) begin
				if (live) begin
					avg_q[cmd.channel] <= avg_new;
					if (hit) begin
						pub_q[cmd.channel] <= avg_new;
					end
				end
				start_q <= start_nx;
				if (cmd.eop) begin
					first_q <= 1'b0;
					err_q   <= 1'b0;
				end else begin
					err_q <= err_now;
				end
			end
			if (ld1) begin
				v1_s1 <= !q_empty;
			end
			if (ld2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1      <= cmd.channel;
			avg_s1     <= !cmd.in_range ? 16'sd0 : (live ? avg_new : cur_avg);
			pub_s1     <= !cmd.in_range ? 16'sd0 : ((live && hit) ? avg_new : cur_pub);
			chg_s1     <= live && hit;
			timer_s1   <= start_nx != '0;
			elapsed_s1 <= cmd.now_ms - start_nx;
		end
	end

	// divide by 1000 through a reciprocal; exact below the saturation point
	assign prod_w = tcad_pkg::PROD_W'(elapsed_s1[tcad_pkg::ELAPSED_W-1:0])
		* tcad_pkg::PROD_W'(tcad_pkg::RECIP);

	always_comb begin
		if (!timer_s1) begin
			secs_w = '0;
		end else if (elapsed_s1 >= 32'(tcad_pkg::SAT_MS)) begin
			secs_w = 8'(tcad_pkg::SECS_MAX);
		end else begin
			secs_w = prod_w[tcad_pkg::RECIP_SHIFT +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && v1_s1) begin
			res_s2.channel           <= ch_s1;
			res_s2.average_centi     <= avg_s1;
			res_s2.published_centi   <= pub_s1;
			res_s2.published_changed <= chg_s1;
			res_s2.error_seconds     <= secs_w;
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	localparam int SETTLE = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 315;

	typedef enum logic [1:0] {PEND_ITEM, PEND_CFG, PEND_DRAIN} pend_kind_t;

	typedef struct {
		pend_kind_t          kind;
		tcad_pkg::in_word_t  w;
		logic [7:0]          db;
	} pend_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 empty;
	logic                 pop;
	logic                 cfg_we;
	logic [7:0]           cfg_data;
	tcad_pkg::in_word_t   item;
	tcad_pkg::out_word_t  result;

	pend_t               pend_q[$];
	tcad_pkg::out_word_t conditioned_q[$];
	int                  errors = 0;
	int                  send_wait = 0, send_calm = 0;
	int                  recv_wait = 0, recv_calm = 0;
	int                  idle_cycles = 0;
	int                  temp_walk[tcad_pkg::SENSORS];

	// predictor state
	logic signed [15:0] avg_mem[tcad_pkg::SENSORS];
	logic signed [15:0] pub_mem[tcad_pkg::SENSORS];
	logic               seed_pass = 1'b1;
	logic               pass_fault = 1'b0;
	logic [31:0]        fault_since_ms = '0;
	logic [7:0]         deadband = tcad_pkg::DEADBAND_RESET;

	temp_channel_average_deadband i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	function automatic tcad_pkg::out_word_t condition_reading(tcad_pkg::in_word_t w);
		tcad_pkg::out_word_t r;
		int                  sum, avg, pub, db;
		logic [31:0]         el;
		r = '0;
		r.channel = w.sensor_index;
		if (w.disconnected) begin
			pass_fault = 1'b1;
		end else begin
			sum = $signed(w.reading_centi) + $signed(w.offset_centi);
			if (sum > 32767) sum = 32767;
			if (sum < -32768) sum = -32768;
			if (seed_pass) avg = sum;
			else avg = (int'(avg_mem[w.sensor_index]) + sum) / 2;
			avg_mem[w.sensor_index] = 16'(avg);
			if (w.publish_pass) begin
				pub = int'(pub_mem[w.sensor_index]);
				db = int'(deadband);
				if (avg >= pub + db || avg <= pub - db) begin
					pub_mem[w.sensor_index] = 16'(avg);
					r.published_changed = 1'b1;
				end
			end
		end
		r.average_centi = avg_mem[w.sensor_index];
		r.published_centi = pub_mem[w.sensor_index];
		if (w.end_of_pass) begin
			if (pass_fault) begin
				if (fault_since_ms == 0) fault_since_ms = (w.now_ms == 0) ? 32'd1 : w.now_ms;
			end else begin
				fault_since_ms = '0;
			end
			seed_pass = 1'b0;
			pass_fault = 1'b0;
		end
		if (fault_since_ms != 0) begin
			el = (w.now_ms - fault_since_ms) / 32'd1000;
			r.error_seconds = (el > 255) ? 8'd255 : el[7:0];
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int gap_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 2) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 110) return 0;
		if (r < 180) return $urandom_range(1, 3);
		if (r < 196) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic tcad_pkg::in_word_t mk(int ch, int rd, int disc, int off, int pub,
			int eop, logic [31:0] now);
		tcad_pkg::in_word_t w;
		w.sensor_index = tcad_pkg::CH_W'(ch);
		w.reading_centi = 16'(rd);
		w.disconnected = 1'(disc);
		w.offset_centi = 16'(off);
		w.publish_pass = 1'(pub);
		w.end_of_pass = 1'(eop);
		w.now_ms = now;
		return w;
	endfunction

	task automatic add_item(tcad_pkg::in_word_t w);
		pend_t p;
		p.kind = PEND_ITEM;
		p.w = w;
		p.db = '0;
		pend_q.push_back(p);
	endtask

	task automatic add_cfg(logic [7:0] v);
		pend_t p;
		p.kind = PEND_CFG;
		p.w = '0;
		p.db = v;
		pend_q.push_back(p);
	endtask

	task automatic add_drain();
		pend_t p;
		p.kind = PEND_DRAIN;
		p.w = '0;
		p.db = '0;
		pend_q.push_back(p);
	endtask

	task automatic add_noise(inout int n);
		tcad_pkg::in_word_t w;
		w.sensor_index = tcad_pkg::CH_W'($urandom_range(0, tcad_pkg::SENSORS - 1));
		w.reading_centi = 16'($urandom);
		w.disconnected = 1'($urandom_range(0, 1));
		w.offset_centi = 16'($urandom);
		w.publish_pass = 1'($urandom_range(0, 1));
		w.end_of_pass = ($urandom_range(0, 3) == 0);
		w.now_ms = $urandom;
		add_item(w);
		n++;
	endtask

	// one pass over the sensors, usually all of them in order
	task automatic add_pass(inout logic [31:0] t, inout int n);
		int  cnt, ch, rd, off, r;
		bit  faulty, pub, ordered;
		faulty = ($urandom_range(0, 3) == 0);
		pub = 1'($urandom_range(0, 1));
		ordered = ($urandom_range(0, 4) != 0);
		cnt = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, tcad_pkg::SENSORS))
			: tcad_pkg::SENSORS;
		for (int k = 0; k < cnt; k++) begin
			ch = ordered ? k : int'($urandom_range(0, tcad_pkg::SENSORS - 1));
			temp_walk[ch] = temp_walk[ch] + int'($urandom_range(0, 60)) - 30;
			if (temp_walk[ch] > 12000) temp_walk[ch] = 12000;
			if (temp_walk[ch] < -4000) temp_walk[ch] = -4000;
			r = $urandom_range(0, 99);
			if (r < 2) rd = 32767;
			else if (r < 4) rd = -32768;
			else if (r < 6) rd = int'($urandom);
			else rd = temp_walk[ch];
			off = ($urandom_range(0, 9) == 0) ? int'($urandom) : int'($urandom_range(0, 200)) - 100;
			add_item(mk(ch, rd, int'(faulty && ($urandom_range(0, 3) == 0)), off, int'(pub),
				int'(k == cnt - 1), t));
			n++;
			t += $urandom_range(0, 25);
		end
		r = $urandom_range(0, 99);
		if (r < 70) t += $urandom_range(200, 3000);
		else if (r < 95) t += $urandom_range(1000, 60000);
		else t += $urandom_range(100000, 400000);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// driver: words and register writes from pend_q
	always @(posedge clk) begin
		logic               nxt_push, nxt_we;
		logic [7:0]         nxt_data;
		tcad_pkg::in_word_t nxt_item;
		nxt_push = 1'b0;
		nxt_we = 1'b0;
		nxt_data = cfg_data;
		nxt_item = item;
		if (arst_n) begin
			if (push && !full) begin
				conditioned_q.push_back(condition_reading(item));
				void'(pend_q.pop_front());
				send_wait = gap_len(send_calm);
			end else if (!push && send_wait > 0) begin
				send_wait--;
			end
			if (conditioned_q.size() == 0) idle_cycles++;
			else idle_cycles = 0;
			if (push && full) begin
				nxt_push = 1'b1;
			end else if (send_wait == 0 && pend_q.size() > 0) begin
				case (pend_q[0].kind)
					PEND_ITEM: begin
						nxt_push = 1'b1;
						nxt_item = pend_q[0].w;
					end
					PEND_CFG: begin
						if (idle_cycles >= SETTLE) begin
							nxt_we = 1'b1;
							nxt_data = pend_q[0].db;
							deadband = pend_q[0].db;
							void'(pend_q.pop_front());
						end
					end
					default: begin
						if (conditioned_q.size() == 0) void'(pend_q.pop_front());
					end
				endcase
			end
		end
		push <= nxt_push;
		item <= nxt_item;
		cfg_we <= nxt_we;
		cfg_data <= nxt_data;
	end

	// monitor: check each popped word against the oldest prediction
	always @(posedge clk) begin
		tcad_pkg::out_word_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (conditioned_q.size() == 0) begin
					$display("%0t unexpected word: expected none, actual %h", $time, result);
					errors++;
				end else begin
					want = conditioned_q.pop_front();
					if (result.channel !== want.channel) begin
						$display("%0t channel: expected %0d, actual %0d", $time,
							want.channel, result.channel);
						errors++;
					end
					if (result.average_centi !== want.average_centi) begin
						$display("%0t average_centi: expected %0d, actual %0d", $time,
							want.average_centi, result.average_centi);
						errors++;
					end
					if (result.published_centi !== want.published_centi) begin
						$display("%0t published_centi: expected %0d, actual %0d", $time,
							want.published_centi, result.published_centi);
						errors++;
					end
					if (result.published_changed !== want.published_changed) begin
						$display("%0t published_changed: expected %0d, actual %0d", $time,
							want.published_changed, result.published_changed);
						errors++;
					end
					if (result.error_seconds !== want.error_seconds) begin
						$display("%0t error_seconds: expected %0d, actual %0d", $time,
							want.error_seconds, result.error_seconds);
						errors++;
					end
				end
				recv_wait = gap_len(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			pop <= (recv_wait == 0);
		end
	end

	initial begin
		logic [31:0] t;
		int          n;
		logic [7:0]  db;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		item = '0;
		for (int i = 0; i < tcad_pkg::SENSORS; i++) begin
			avg_mem[i] = '0;
			pub_mem[i] = '0;
			temp_walk[i] = 1500 + int'($urandom_range(0, 2000));
		end

		// first pass seeds averages, sums saturate both ways, timer starts at time zero
		add_item(mk(0, 2500, 0, 0, 1, 0, 0));
		add_item(mk(1, 32767, 0, 32767, 1, 0, 0));
		add_item(mk(2, -32768, 0, -32768, 1, 0, 0));
		add_item(mk(3, 100, 0, -5, 0, 0, 0));
		add_item(mk(4, 32767, 1, 0, 1, 0, 0));
		add_item(mk(15, 2000, 0, 3, 1, 1, 0));
		// averaging, deadband hold and follow, truncation toward zero
		add_item(mk(0, 2510, 0, 0, 1, 0, 500));
		add_item(mk(0, 2530, 0, 0, 1, 0, 600));
		add_item(mk(1, -32768, 0, 0, 1, 0, 700));
		add_item(mk(2, -1, 0, 0, 1, 0, 800));
		add_item(mk(5, -3, 0, 0, 0, 0, 900));
		add_item(mk(6, 0, 0, 0, 1, 1, 2500));
		// timer across the 32-bit wrap, then a clean pass clears it
		add_item(mk(7, 0, 1, 0, 1, 1, 32'hFFFF_FF00));
		add_item(mk(8, 10, 0, 0, 0, 0, 32'h0000_0100));
		add_item(mk(8, 0, 1, 0, 0, 1, 32'h0000_2000));
		add_item(mk(9, 20, 0, 0, 1, 1, 32'h000F_0000));
		// zero deadband: equal average still publishes
		add_cfg(8'd0);
		add_item(mk(0, 2517, 0, 0, 1, 0, 32'h0010_0000));
		add_item(mk(3, -32768, 0, -1, 1, 1, 32'h0010_0010));
		add_cfg(8'd255);
		add_item(mk(0, 3117, 0, 0, 1, 0, 32'h0010_0100));
		add_item(mk(0, 3120, 0, 0, 1, 0, 32'h0010_0200));
		add_item(mk(10, 0, 1, 0, 1, 1, 32'h0010_0300));
		add_item(mk(11, 1000, 0, 0, 1, 1, 32'h0050_0300));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: db = 8'd255;
				1: db = 8'd0;
				2: db = 8'd1;
				4: db = 8'd128;
				default: db = 8'($urandom_range(0, 255));
			endcase
			add_cfg(db);
			t = (ph == 2) ? 32'hFFF8_0000 : $urandom;
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) add_noise(n);
				else add_pass(t, n);
				if (ph == 3 && n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 16) add_drain();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || conditioned_q.size() != 0 || push) @(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
